@@ src/asgr_pkg.sv @@
package asgr_pkg;

    // sequence buffer geometry
    localparam int SEQ_BUF_LEN = 16;
    localparam int ADDR_W      = $clog2(SEQ_BUF_LEN);
    localparam int LEN_W       = $clog2(SEQ_BUF_LEN);
    localparam int PTR_W       = $clog2(SEQ_BUF_LEN + 2);

    // bytes with a meaning to the parser
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_9    = 8'h39;

    // colour modes
    localparam logic [1:0] FG_DEFAULT = 2'd0;
    localparam logic [1:0] FG_NORMAL  = 2'd1;
    localparam logic [1:0] FG_BRIGHT  = 2'd2;
    localparam logic       BG_DEFAULT = 1'b0;
    localparam logic       BG_NORMAL  = 1'b1;

    // result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_ATTR = 1'b1;

    typedef logic [7:0] byte_t;
    typedef byte_t [3:0] window_t;

    typedef struct packed {
        logic [1:0] fg_mode;
        logic [2:0] fg_index;
        logic       bg_mode;
        logic [2:0] bg_index;
        logic       bold;
    } attr_t;

    typedef struct packed {
        attr_t      attr;
        logic [1:0] adv;
        logic       cont;
    } step_res_t;

    function automatic logic is_end(input byte_t c);
        return (c == CH_SEMI) || (c == CH_M);
    endfunction

    function automatic logic is_dig07(input byte_t c);
        return c[7:3] == 5'b00110;
    endfunction

    function automatic logic is_letter(input byte_t c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

@@ src/asgr_step.sv @@
module asgr_step (
    input  asgr_pkg::window_t   win,
    input  asgr_pkg::attr_t     attr_i,
    output asgr_pkg::step_res_t res
);

    logic            one;
    logic            two;
    logic            three;
    asgr_pkg::byte_t nxt;

    // parameter length classes from the window after the lead byte
    assign one   = asgr_pkg::is_end(win[1]);
    assign two   = (win[1] != 8'd0) && !asgr_pkg::is_end(win[1]) && asgr_pkg::is_end(win[2]);
    assign three = (win[1] != 8'd0) && !asgr_pkg::is_end(win[1]) &&
                   (win[2] != 8'd0) && !asgr_pkg::is_end(win[2]) && asgr_pkg::is_end(win[3]);

    // one parameter step
    always_comb begin
        res.attr = attr_i;
        res.adv  = 2'd1;
        case (win[0])
            asgr_pkg::CH_0: begin
                if (one) begin
                    res.attr = '0;
                end
            end
            asgr_pkg::CH_1: begin
                if (one) begin
                    res.attr.bold = 1'b1;
                end else if (three) begin
                    res.adv = 2'd3;
                    if (asgr_pkg::is_dig07(win[2])) begin
                        res.attr.fg_mode  = asgr_pkg::FG_BRIGHT;
                        res.attr.fg_index = win[2][2:0];
                    end
                end
            end
            asgr_pkg::CH_2: begin
                if (two) begin
                    res.adv = 2'd2;
                    if (win[1] == asgr_pkg::CH_2) begin
                        res.attr.bold = 1'b0;
                    end
                end
            end
            asgr_pkg::CH_3: begin
                if (two) begin
                    res.adv = 2'd2;
                    if (asgr_pkg::is_dig07(win[1])) begin
                        res.attr.fg_mode  = asgr_pkg::FG_NORMAL;
                        res.attr.fg_index = win[1][2:0];
                    end else if (win[1] == asgr_pkg::CH_9) begin
                        res.attr.fg_mode  = asgr_pkg::FG_DEFAULT;
                        res.attr.fg_index = 3'd0;
                    end
                end
            end
            asgr_pkg::CH_4: begin
                if (two) begin
                    res.adv = 2'd2;
                    if (asgr_pkg::is_dig07(win[1])) begin
                        res.attr.bg_mode  = asgr_pkg::BG_NORMAL;
                        res.attr.bg_index = win[1][2:0];
                    end else if (win[1] == asgr_pkg::CH_9) begin
                        res.attr.bg_mode  = asgr_pkg::BG_DEFAULT;
                        res.attr.bg_index = 3'd0;
                    end
                end
            end
            asgr_pkg::CH_9: begin
                if (two) begin
                    res.adv = 2'd2;
                    if (asgr_pkg::is_dig07(win[1])) begin
                        res.attr.fg_mode  = asgr_pkg::FG_BRIGHT;
                        res.attr.fg_index = win[1][2:0];
                    end
                end
            end
            default: begin
                res.adv = 2'd1;
            end
        endcase

        // carry on only when a separator follows the step
        nxt      = win[res.adv];
        res.cont = (nxt == asgr_pkg::CH_SEMI);
    end

endmodule

@@ src/ansi_sgr_escape_filter.sv @@
// Plain characters: an accepted item goes straight into the registered result.
// Buffered sequence bytes: one cycle each while the output is free, no result until the sequence closes.
// Dumping a sequence: each byte is read (one buffer read port), then offered; up to 15 bytes.
// SGR decode: each parameter step is four window reads and one step; then the result is emitted.
// Synchronous active-low reset clears control, length and attributes; the buffer is not cleared.
module ansi_sgr_escape_filter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_char_code,
    output logic [1:0] m_fg_mode,
    output logic [2:0] m_fg_index,
    output logic       m_bg_mode,
    output logic [2:0] m_bg_index,
    output logic       m_bold_on,
    output logic       m_last
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_FETCH    = 6'b000010,
        ST_STEP     = 6'b000100,
        ST_EMIT     = 6'b001000,
        ST_DUMP_RD  = 6'b010000,
        ST_DUMP_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // sequence buffer
    asgr_pkg::byte_t mem [asgr_pkg::SEQ_BUF_LEN];
    asgr_pkg::byte_t rd_data_reg;
    logic                        wr_en;
    logic [asgr_pkg::ADDR_W-1:0] wr_addr;
    logic                        rd_en;
    logic [asgr_pkg::ADDR_W-1:0] rd_addr;

    logic [asgr_pkg::LEN_W-1:0] len_reg, len_next;
    logic [asgr_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic [asgr_pkg::LEN_W-1:0] new_len;
    logic [asgr_pkg::PTR_W-1:0] ptr_reg, ptr_next;
    logic [asgr_pkg::PTR_W-1:0] fetch_addr;
    logic [2:0]                 fk_reg, fk_next;
    logic [1:0]                 fk_m1;
    logic                       rng_reg, rng_next;
    asgr_pkg::window_t          win_reg, win_next;

    asgr_pkg::attr_t     attr_reg, attr_next;
    asgr_pkg::step_res_t step_res;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic            out_kind_reg, out_kind_next;
    asgr_pkg::byte_t out_char_reg, out_char_next;
    asgr_pkg::attr_t out_attr_reg, out_attr_next;
    logic            out_last_reg, out_last_next;
    logic            out_free;
    logic            accept;

    asgr_step u_step (
        .win    (win_reg),
        .attr_i (attr_reg),
        .res    (step_res)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign new_len  = len_reg + asgr_pkg::LEN_W'(1);
    assign fetch_addr = ptr_reg + asgr_pkg::PTR_W'(fk_reg[1:0]);
    assign fk_m1    = 2'(fk_reg - 3'd1);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        fk_next        = fk_reg;
        rng_next       = rng_reg;
        win_next       = win_reg;
        attr_next      = attr_reg;
        wr_en          = 1'b0;
        wr_addr        = len_reg[asgr_pkg::ADDR_W-1:0];
        rd_en          = 1'b0;
        rd_addr        = idx_reg[asgr_pkg::ADDR_W-1:0];
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((len_reg != '0) || (s_in_byte == asgr_pkg::CH_ESC)) begin
                        // append to the open sequence
                        wr_en    = 1'b1;
                        len_next = new_len;
                        idx_next = '0;
                        if (((new_len == asgr_pkg::LEN_W'(2)) &&
                             (s_in_byte != asgr_pkg::CH_LBR)) ||
                            (len_reg == asgr_pkg::LEN_W'(asgr_pkg::SEQ_BUF_LEN - 2))) begin
                            state_next = ST_DUMP_RD;
                        end else if (asgr_pkg::is_letter(s_in_byte)) begin
                            if (s_in_byte == asgr_pkg::CH_M) begin
                                ptr_next   = asgr_pkg::PTR_W'(2);
                                fk_next    = 3'd0;
                                state_next = ST_FETCH;
                            end else begin
                                len_next = '0;
                            end
                        end
                    end else begin
                        // plain character straight through
                        out_valid_next = 1'b1;
                        out_kind_next  = asgr_pkg::KIND_CHAR;
                        out_char_next  = s_in_byte;
                        out_attr_next  = attr_reg;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                // read the four-byte window, reads past the end give 'm'
                if (fk_reg != 3'd4) begin
                    rd_en    = 1'b1;
                    rd_addr  = fetch_addr[asgr_pkg::ADDR_W-1:0];
                    rng_next = fetch_addr < asgr_pkg::PTR_W'(len_reg);
                end
                if (fk_reg != 3'd0) begin
                    win_next[fk_m1] = rng_reg ? rd_data_reg : asgr_pkg::CH_M;
                end
                if (fk_reg == 3'd4) begin
                    fk_next    = 3'd0;
                    state_next = ST_STEP;
                end else begin
                    fk_next = fk_reg + 3'd1;
                end
            end
            ST_STEP: begin
                attr_next = step_res.attr;
                if (step_res.cont) begin
                    ptr_next   = ptr_reg + asgr_pkg::PTR_W'(step_res.adv);
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = asgr_pkg::KIND_ATTR;
                    out_char_next  = 8'd0;
                    out_attr_next  = attr_reg;
                    out_last_next  = 1'b1;
                    len_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_DUMP_RD: begin
                rd_en      = 1'b1;
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = asgr_pkg::KIND_CHAR;
                    out_char_next  = rd_data_reg;
                    out_attr_next  = attr_reg;
                    out_last_next  = (idx_reg == len_reg - asgr_pkg::LEN_W'(1));
                    if (out_last_next) begin
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + asgr_pkg::LEN_W'(1);
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // buffer write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            attr_reg      <= '0;
            out_valid_reg <= 1'b0;
            fk_reg        <= 3'd0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
            fk_reg        <= fk_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        rng_reg      <= rng_next;
        win_reg      <= win_next;
        out_kind_reg <= out_kind_next;
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_kind      = out_kind_reg;
    assign m_char_code = out_char_reg;
    assign m_fg_mode   = out_attr_reg.fg_mode;
    assign m_fg_index  = out_attr_reg.fg_index;
    assign m_bg_mode   = out_attr_reg.bg_mode;
    assign m_bg_index  = out_attr_reg.bg_index;
    assign m_bold_on   = out_attr_reg.bold;
    assign m_last      = out_last_reg;

endmodule

@@ src/asgr_checker.sv @@
module asgr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_kind,
    input logic [7:0] m_char_code,
    input logic [1:0] m_fg_mode,
    input logic [2:0] m_fg_index,
    input logic       m_bg_mode,
    input logic [2:0] m_bg_index,
    input logic       m_bold_on,
    input logic       m_last
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_char_code) &&
        $stable(m_fg_mode) && $stable(m_fg_index) && $stable(m_bg_mode) &&
        $stable(m_bg_index) && $stable(m_bold_on) && $stable(m_last))
        else $error("result item changed while stalled");

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an attribute update is a single item carrying no character
    a_attr_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == asgr_pkg::KIND_ATTR) |-> m_last && (m_char_code == 8'd0))
        else $error("attribute item malformed");

    // default foreground carries index zero and no reserved mode
    a_fg_default: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_fg_mode == asgr_pkg::FG_DEFAULT) ||
                     (m_fg_mode == asgr_pkg::FG_NORMAL) ||
                     (m_fg_mode == asgr_pkg::FG_BRIGHT)) &&
                    ((m_fg_mode != asgr_pkg::FG_DEFAULT) || (m_fg_index == 3'd0)))
        else $error("foreground state inconsistent");

    // default background carries index zero
    a_bg_default: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_bg_mode == asgr_pkg::BG_DEFAULT) |-> (m_bg_index == 3'd0))
        else $error("background state inconsistent");

endmodule

bind ansi_sgr_escape_filter asgr_checker u_asgr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_char_code (m_char_code),
    .m_fg_mode   (m_fg_mode),
    .m_fg_index  (m_fg_index),
    .m_bg_mode   (m_bg_mode),
    .m_bg_index  (m_bg_index),
    .m_bold_on   (m_bold_on),
    .m_last      (m_last)
);
